>>> rtl/core/serial_acia_registers_unit_macros.svh
// ---------------------------------------------------------------------------
// Serial ACIA register unit assertion macros
// Shared assertion forms for the checker of the register unit.
// ---------------------------------------------------------------------------
`ifndef SERIAL_ACIA_REGISTERS_UNIT_MACROS_SVH
`define SERIAL_ACIA_REGISTERS_UNIT_MACROS_SVH

// assertion muted while reset is high
`define SACIA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// assertion that also holds across reset
`define SACIA_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

>>> rtl/core/sacia_pkg.sv
// ---------------------------------------------------------------------------
// Serial ACIA register unit package
// Command codes, status constants and request/response types.
// ---------------------------------------------------------------------------
`default_nettype none

package sacia_pkg;

   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_READ_STATUS = 3'd1;
   localparam logic [2:0] CMD_WRITE_CTRL  = 3'd2;
   localparam logic [2:0] CMD_READ_DATA   = 3'd3;
   localparam logic [2:0] CMD_WRITE_DATA  = 3'd4;

   localparam logic       CSR_RX_PRESENT  = 1'b0;
   localparam logic       CSR_TX_PRESENT  = 1'b1;

   localparam logic [7:0] RUBOUT          = 8'h7f;
   localparam logic [7:0] BACKSPACE       = 8'h08;

   localparam int         CTRL_INTR_EN    = 7;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] bus_data;
      logic       rx_available;
      logic [7:0] rx_byte;
      logic       tx_ready;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/sacia_in_stage.sv
// ---------------------------------------------------------------------------
// Serial ACIA request register
// Captures one request a cycle and holds it until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sacia_in_stage
   import sacia_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [2:0]  req_tuser,
   input  wire logic [23:0] req_tdata,
   input  wire logic        advance,
   output      logic        item_valid,
   output      req_type     item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.cmd          <= req_tuser;
         item_ff.bus_data     <= req_tdata[7:0];
         item_ff.rx_available <= req_tdata[8];
         item_ff.rx_byte      <= req_tdata[16:9];
         item_ff.tx_ready     <= req_tdata[17];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> rtl/core/sacia_regs.sv
// ---------------------------------------------------------------------------
// Serial ACIA register core
// Holds status, control and data registers and works out each response.
// ---------------------------------------------------------------------------
`default_nettype none

module sacia_regs
   import sacia_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_we,
   input  wire logic    csr_index,
   input  wire logic    csr_data,
   input  wire logic    advance,
   input  wire req_type item,
   output      rsp_type result
);

   logic       rx_present_ff, tx_present_ff;
   logic       rx_full_ff, tx_empty_ff, intr_ff, intr_en_ff, enabled_ff;
   logic [7:0] rx_hold_ff, tx_hold_ff;

   logic       rx_full_in, tx_empty_in, intr_in, intr_en_in, enabled_in;
   logic [7:0] rx_hold_in, tx_hold_in;
   logic       take_rx, take_tx;

   always_comb begin
      rx_full_in  = rx_full_ff;
      tx_empty_in = tx_empty_ff;
      intr_in     = intr_ff;
      intr_en_in  = intr_en_ff;
      enabled_in  = enabled_ff;
      rx_hold_in  = rx_hold_ff;
      tx_hold_in  = tx_hold_ff;
      result      = '0;
      take_rx     = rx_present_ff && !rx_full_ff && item.rx_available;
      take_tx     = tx_present_ff && !tx_empty_ff && item.tx_ready;
      case (item.cmd)
         CMD_TICK: begin
            if (enabled_ff) begin
               if (take_rx) begin
                  rx_full_in = 1'b1;
                  intr_in    = 1'b1;
                  rx_hold_in = item.rx_byte;
               end
               if (take_tx) begin
                  tx_empty_in     = 1'b1;
                  result.tx_valid = 1'b1;
                  result.tx_byte  = tx_hold_ff;
               end
               result.irq = (intr_ff || take_rx) && intr_en_ff;
            end
         end
         CMD_READ_STATUS, CMD_WRITE_CTRL: begin
            if (!enabled_ff) begin
               rx_full_in  = 1'b0;
               tx_empty_in = 1'b1;
               intr_in     = 1'b0;
               enabled_in  = rx_present_ff || tx_present_ff;
            end
            if (item.cmd == CMD_WRITE_CTRL) begin
               intr_en_in       = item.bus_data[CTRL_INTR_EN];
               result.read_data = item.bus_data;
            end else begin
               result.read_data = {intr_in, 5'b0, tx_empty_in, rx_full_in};
            end
         end
         CMD_READ_DATA: begin
            result.read_data = item.bus_data;
            if (rx_full_ff) begin
               rx_full_in       = 1'b0;
               intr_in          = 1'b0;
               result.read_data = (rx_hold_ff == RUBOUT) ? BACKSPACE : rx_hold_ff;
            end
         end
         CMD_WRITE_DATA: begin
            result.read_data = item.bus_data;
            if (tx_empty_ff) begin
               tx_empty_in = 1'b0;
               tx_hold_in  = item.bus_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_present_ff <= 1'b1;
         tx_present_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RX_PRESENT: rx_present_ff <= csr_data;
            CSR_TX_PRESENT: tx_present_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_full_ff  <= 1'b0;
         tx_empty_ff <= 1'b0;
         intr_ff     <= 1'b0;
         intr_en_ff  <= 1'b0;
         enabled_ff  <= 1'b0;
         rx_hold_ff  <= '0;
         tx_hold_ff  <= '0;
      end else if (advance) begin
         rx_full_ff  <= rx_full_in;
         tx_empty_ff <= tx_empty_in;
         intr_ff     <= intr_in;
         intr_en_ff  <= intr_en_in;
         enabled_ff  <= enabled_in;
         rx_hold_ff  <= rx_hold_in;
         tx_hold_ff  <= tx_hold_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sacia_out_stage.sv
// ---------------------------------------------------------------------------
// Serial ACIA response register
// Holds one response until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sacia_out_stage
   import sacia_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire rsp_type     result,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.tx_byte, rsp_ff.tx_valid, rsp_ff.irq, rsp_ff.read_data};

endmodule

`default_nettype wire

>>> rtl/core/serial_acia_registers_unit.sv
// Flow: a request waits in the request register, then its response in the response register.
// Throughput: one request per cycle unless rsp_tready holds a response; the request register,
// the register core logic and the response register form a single pass with no iteration.
// Reset: synchronous, active high; clears both stages, status, control and data registers,
// and sets both channel-present registers.
// ---------------------------------------------------------------------------
// Serial ACIA register unit
// Register block of a simplified ACIA answering bus accesses and line ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_acia_registers_unit
   import sacia_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [2:0]  req_tuser,   // cmd
   input  wire logic [23:0] req_tdata,   // bus_data, rx_available, rx_byte, tx_ready
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,   // read_data, irq, tx_valid, tx_byte
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic        csr_data
);

   logic    item_valid;
   logic    advance;
   req_type item;
   rsp_type result;

   assign advance = item_valid && (!rsp_tvalid || rsp_tready);

   sacia_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sacia_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (advance),
      .item      (item),
      .result    (result)
   );

   sacia_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/core/sacia_checker.sv
// ---------------------------------------------------------------------------
// Serial ACIA register unit checker
// Port-level checks on flow through the request and response stages.
// ---------------------------------------------------------------------------
`default_nettype none

`include "serial_acia_registers_unit_macros.svh"

module sacia_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   `SACIA_ASSERT(rsp_hold_chk, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `SACIA_ASSERT_RST(rsp_reset_chk, reset |=> !rsp_tvalid)
   `SACIA_ASSERT(req_ready_chk, !rsp_tvalid |-> req_tready)
   `SACIA_ASSERT(req_flow_chk, (req_tvalid && req_tready) ##1 !rsp_tvalid |=> rsp_tvalid)

endmodule

bind serial_acia_registers_unit sacia_checker u_sacia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> dv/serial_acia_registers_unit_tb.sv
// ---------------------------------------------------------------------------
// Serial ACIA register unit testbench
// Drives bus accesses and line ticks into the register unit, predicts every
// response from a behavioural copy of the status, control and data registers,
// and compares each response field by field. Runs a directed opening, then
// random traffic under several channel-present settings, with random gaps on
// both streams, one long response hold-off and pauses until the block drains.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_acia_registers_unit_tb;
   import sacia_pkg::*;

   localparam logic [7:0] STAT_RX_FULL  = 8'h01;
   localparam logic [7:0] STAT_TX_EMPTY = 8'h02;
   localparam logic [7:0] STAT_INTR     = 8'h80;
   localparam logic [2:0] CMD_TOP_CODE  = 3'd7;
   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         HOLD_CYCLES   = 150;
   localparam int         HALF_PHASE    = 155;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_RX_PRESENT;
   logic        csr_data = 1'b0;

   serial_acia_registers_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // register copy
   logic       rx_line_on = 1'b1;
   logic       tx_line_on = 1'b1;
   logic [7:0] acia_status = '0;
   logic [7:0] acia_control = '0;
   logic [7:0] rx_latch = '0;
   logic [7:0] tx_latch = '0;
   logic       acia_enabled = 1'b0;

   req_type pending_requests[$];
   rsp_type expected_responses[$];
   req_type offered_req;

   int  send_gap = 0;
   int  recv_stall = 0;
   int  hold_requests = 0;
   int  hold_served = 0;
   bit  idle_enabled = 1'b1;
   int  fault_count = 0;
   int  cycle_count = 0;
   int  request_count = 0;
   int  response_count = 0;
   int  irq_count = 0;
   int  sent_count = 0;
   int  backspace_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void open_on_first_access();
      if (!acia_enabled) begin
         acia_status = STAT_TX_EMPTY;
         if (rx_line_on || tx_line_on)
            acia_enabled = 1'b1;
      end
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type o;
      logic    take_rx;
      logic    take_tx;
      o = '0;
      case (r.cmd)
         CMD_TICK: begin
            if (acia_enabled) begin
               take_rx = rx_line_on && !(acia_status & STAT_RX_FULL);
               take_tx = tx_line_on && !(acia_status & STAT_TX_EMPTY);
               if (take_rx && r.rx_available) begin
                  acia_status = acia_status | STAT_RX_FULL | STAT_INTR;
                  rx_latch = r.rx_byte;
               end
               if (take_tx && r.tx_ready) begin
                  acia_status = acia_status | STAT_TX_EMPTY;
                  o.tx_valid = 1'b1;
                  o.tx_byte = tx_latch;
                  sent_count++;
               end
               if ((acia_status & STAT_INTR) != 0 && acia_control[CTRL_INTR_EN]) begin
                  o.irq = 1'b1;
                  irq_count++;
               end
            end
         end
         CMD_READ_STATUS: begin
            open_on_first_access();
            o.read_data = acia_status;
         end
         CMD_WRITE_CTRL: begin
            open_on_first_access();
            acia_control = r.bus_data;
            o.read_data = r.bus_data;
         end
         CMD_READ_DATA: begin
            o.read_data = r.bus_data;
            if (acia_status & STAT_RX_FULL) begin
               acia_status = acia_status & ~(STAT_RX_FULL | STAT_INTR);
               if (rx_latch == RUBOUT) begin
                  o.read_data = BACKSPACE;
                  backspace_count++;
               end else begin
                  o.read_data = rx_latch;
               end
            end
         end
         CMD_WRITE_DATA: begin
            if (acia_status & STAT_TX_EMPTY) begin
               acia_status = acia_status & ~STAT_TX_EMPTY;
               tx_latch = r.bus_data;
            end
            o.read_data = r.bus_data;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enabled || roll < 60)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_type make_request(logic [2:0] cmd, logic [7:0] bus, logic rxa,
                                            logic [7:0] rxb, logic txr);
      req_type r;
      r.cmd = cmd;
      r.bus_data = bus;
      r.rx_available = rxa;
      r.rx_byte = rxb;
      r.tx_ready = txr;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.bus_data = 8'($urandom_range(0, 255));
      r.rx_available = 1'($urandom_range(0, 1));
      r.rx_byte = ($urandom_range(0, 9) == 0) ? RUBOUT : 8'($urandom_range(0, 255));
      r.tx_ready = 1'($urandom_range(0, 1));
      if (roll < 40)
         r.cmd = CMD_TICK;
      else if (roll < 50)
         r.cmd = CMD_READ_STATUS;
      else if (roll < 58)
         r.cmd = CMD_WRITE_CTRL;
      else if (roll < 78)
         r.cmd = CMD_READ_DATA;
      else if (roll < 95)
         r.cmd = CMD_WRITE_DATA;
      else
         r.cmd = 3'($urandom_range(CMD_WRITE_DATA + 1, CMD_TOP_CODE));
      return r;
   endfunction

   task automatic queue_random(input int count);
      req_type r;
      int      useful;
      useful = 0;
      while (useful < count) begin
         r = random_request();
         pending_requests.push_back(r);
         if (r.cmd <= CMD_WRITE_DATA)
            useful++;
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_presence(input logic rx_on, input logic tx_on);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_RX_PRESENT;
      csr_data <= rx_on;
      @(posedge clock);
      csr_index <= CSR_TX_PRESENT;
      csr_data <= tx_on;
      @(posedge clock);
      csr_we <= 1'b0;
      rx_line_on = rx_on;
      tx_line_on = tx_on;
   endtask

   // request driver
   always @(posedge clock) begin : driver
      req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(predict_response(offered_req));
            request_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_req = pending_requests.pop_front();
               offered_req <= next_req;
               req_tvalid <= 1'b1;
               req_tuser <= next_req.cmd;
               req_tdata <= {6'b0, next_req.tx_ready, next_req.rx_byte,
                             next_req.rx_available, next_req.bus_data};
               send_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[7:0];
            got.irq = rsp_tdata[8];
            got.tx_valid = rsp_tdata[9];
            got.tx_byte = rsp_tdata[17:10];
            response_count++;
            if (expected_responses.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected response: %02h/%0b/%0b/%02h",
                           got.read_data, got.irq, got.tx_valid, got.tx_byte);
            end else begin
               want = expected_responses.pop_front();
               if (got.read_data !== want.read_data || got.irq !== want.irq ||
                   got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch %0d: want %02h/%0b/%0b/%02h got %02h/%0b/%0b/%02h",
                              response_count, want.read_data, want.irq, want.tx_valid,
                              want.tx_byte, got.read_data, got.irq, got.tx_valid, got.tx_byte);
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            recv_stall <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_tready <= 1'b0;
         end else begin
            recv_stall <= pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** serial_acia_registers_unit: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic rx_settings[5];
      logic tx_settings[5];
      rx_settings = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      tx_settings = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_presence(1'b0, 1'b0);

      // disabled block, no channel present
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b1, 8'hff, 1'b1));
      pending_requests.push_back(make_request(CMD_WRITE_DATA, 8'ha5, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_READ_DATA, 8'h3c, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_WRITE_DATA + 3'd1, 8'hff, 1'b1, 8'hff, 1'b1));
      pending_requests.push_back(make_request(CMD_WRITE_DATA + 3'd2, 8'h00, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_TOP_CODE, 8'h81, 1'b1, 8'h7e, 1'b1));
      pending_requests.push_back(make_request(CMD_READ_STATUS, 8'h00, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b1, 8'h55, 1'b1));
      pending_requests.push_back(make_request(CMD_WRITE_DATA, 8'h5a, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_WRITE_CTRL, 8'h80, 1'b0, 8'h00, 1'b0));
      wait_drained();

      // enable and walk both channels
      write_presence(1'b1, 1'b1);
      pending_requests.push_back(make_request(CMD_READ_STATUS, 8'h00, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b1, RUBOUT, 1'b1));
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b1, 8'h11, 1'b0));
      pending_requests.push_back(make_request(CMD_READ_STATUS, 8'hff, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_READ_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_READ_DATA, 8'hff, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_WRITE_DATA, 8'hff, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_WRITE_DATA, 8'h00, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b0, 8'h00, 1'b1));
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b1, 8'h00, 1'b1));
      pending_requests.push_back(make_request(CMD_WRITE_CTRL, 8'h00, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_TICK, 8'hff, 1'b0, 8'hff, 1'b0));
      pending_requests.push_back(make_request(CMD_READ_DATA, 8'h42, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_WRITE_DATA, RUBOUT, 1'b0, 8'h00, 1'b0));
      pending_requests.push_back(make_request(CMD_TICK, 8'h00, 1'b0, 8'h00, 1'b1));
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         write_presence(rx_settings[p], tx_settings[p]);
         idle_enabled = (p != 2);
         queue_random(HALF_PHASE);
         if (p == 0)
            hold_requests <= hold_requests + 1;
         wait_drained();
         queue_random(HALF_PHASE);
         wait_drained();
      end

      idle_enabled = 1'b1;
      repeat (8) @(posedge clock);
      $display("covered %0d requests over five channel settings: %0d interrupts, %0d bytes sent,",
               request_count, irq_count, sent_count);
      $display("%0d rubout reads, %0d faults", backspace_count, fault_count);
      if (fault_count == 0 && expected_responses.size() == 0) begin
         $display("** serial_acia_registers_unit: PASSED **");
      end else begin
         $display("** serial_acia_registers_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
